[hdl/usrh_pkg.sv]
// Shared types, codes and helpers for the USB standard request handler.
// Used by usrh_front, usrh_back, usrh_fifo users and the top level.
package usrh_pkg;

  localparam int STRING_SLOTS_DEFAULT = 4;
  localparam int QUEUE_DEPTH = 2;

  // Event codes of the operation field
  localparam logic [2:0] OP_SETUP    = 3'd0;
  localparam logic [2:0] OP_BUS_RST  = 3'd1;
  localparam logic [2:0] OP_SUSPEND  = 3'd2;
  localparam logic [2:0] OP_RESUME   = 3'd3;
  localparam logic [2:0] OP_IN_DONE  = 3'd4;

  // Standard request codes
  localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;

  // Descriptor types
  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;

  localparam logic [7:0]  TYPE_MASK        = 8'h60;
  localparam logic [7:0]  RECIPIENT_MASK   = 8'h1F;
  localparam logic [7:0]  RECIPIENT_EP     = 8'h02;
  localparam logic [15:0] FEAT_EP_HALT     = 16'd0;
  localparam logic [15:0] FEAT_WAKEUP      = 16'd1;
  localparam logic [31:0] LANGID_REPLY     = 32'h0409_0304;

  // Device states
  localparam logic [2:0] ST_POWERED    = 3'd0;
  localparam logic [2:0] ST_DEFAULT    = 3'd1;
  localparam logic [2:0] ST_ADDRESS    = 3'd2;
  localparam logic [2:0] ST_CONFIGURED = 3'd3;
  localparam logic [2:0] ST_SUSPENDED  = 3'd4;

  // Reply sources
  localparam logic [2:0] SRC_NONE   = 3'd0;
  localparam logic [2:0] SRC_INLINE = 3'd1;
  localparam logic [2:0] SRC_DEVICE = 3'd2;
  localparam logic [2:0] SRC_CONFIG = 3'd3;
  localparam logic [2:0] SRC_STRING = 3'd4;
  localparam logic [2:0] SRC_LANGID = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_DEVICE_LEN  = 3'd0;
  localparam logic [2:0] REG_CONFIG_LEN  = 3'd1;
  localparam logic [2:0] REG_SELF_POWER  = 3'd2;
  localparam logic [2:0] REG_STRING_CNT  = 3'd3;

  localparam logic [7:0] DEVICE_LEN_RESET = 8'd18;

  // Actions handed from the front to the back
  localparam logic [3:0] ACT_NONE        = 4'd0;
  localparam logic [3:0] ACT_SET_ADDRESS = 4'd1;
  localparam logic [3:0] ACT_SET_CONFIG  = 4'd2;
  localparam logic [3:0] ACT_GET_CONFIG  = 4'd3;
  localparam logic [3:0] ACT_GET_STATUS  = 4'd4;
  localparam logic [3:0] ACT_SET_WAKEUP  = 4'd5;
  localparam logic [3:0] ACT_CLR_WAKEUP  = 4'd6;
  localparam logic [3:0] ACT_BUS_RESET   = 4'd7;
  localparam logic [3:0] ACT_SUSPEND     = 4'd8;
  localparam logic [3:0] ACT_RESUME      = 4'd9;
  localparam logic [3:0] ACT_IN_DONE     = 4'd10;

  typedef struct packed {
    logic [3:0]  act;
    logic [7:0]  arg;
    logic        status;
    logic        stall_ep0;
    logic        unhalt_valid;
    logic [7:0]  unhalt_endpoint;
    logic [2:0]  response_source;
    logic [15:0] response_length;
    logic [31:0] inline_data;
    logic [1:0]  string_slot;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic        stall_ep0;
    logic        unhalt_valid;
    logic [7:0]  unhalt_endpoint;
    logic [2:0]  response_source;
    logic [15:0] response_length;
    logic [31:0] inline_data;
    logic [1:0]  string_slot;
    logic [2:0]  device_state;
    logic [6:0]  device_address;
    logic        wakeup_enabled;
    logic        ep0_phase;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  function automatic logic [15:0] clip16(input logic [15:0] n, input logic [15:0] limit);
    return (n > limit) ? limit : n;
  endfunction

endpackage

[hdl/usb_standard_request_handler_core.sv]
// Top level of the USB standard request handler for endpoint zero.
// Depends on usrh_pkg, usrh_front, usrh_fifo and usrh_back.
//
// Usage:
//   Input channel: drive operation and the setup fields, raise push; the item is
//   taken at a clock edge where push is high and full is low. Each item is a
//   setup packet, bus reset, suspend, resume or EP0 IN completion.
//   Result channel: while empty is low the oldest result is on the result ports;
//   it is taken at an edge where pop is high. Every item gives exactly one result.
//   Configuration: write cfg_data to register cfg_index at any edge with
//   cfg_write high; only while no item is in flight.
//   Order: each item is decoded into the command queue at the accepting edge and
//   executed into the result queue at a later edge, once it heads the command
//   queue and the result queue has room; the result is then on the result ports.
//   Throughput: one item per cycle while full stays low; the front decode and
//   the back state update overlap.
//   Reset (rst, synchronous): queues empty, configuration to its defaults, device
//   powered with address, configuration, wakeup and EP0 phase cleared.
//   Stalls: when pop is held low the result queue fills, the back end holds,
//   then the command queue fills and full rises; nothing is dropped.
module usb_standard_request_handler_core import usrh_pkg::*; #(
  parameter int STRING_SLOTS = STRING_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_index,
  input  logic [15:0] request_length,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic        status,
  output logic        stall_ep0,
  output logic        unhalt_valid,
  output logic [7:0]  unhalt_endpoint,
  output logic [2:0]  response_source,
  output logic [15:0] response_length,
  output logic [31:0] inline_data,
  output logic [1:0]  string_slot,
  output logic [2:0]  device_state,
  output logic [6:0]  device_address,
  output logic        wakeup_enabled,
  output logic        ep0_phase
);

  cmd_t             front_cmd;
  logic [CMD_W-1:0] mid_dout;
  cmd_t             back_cmd;
  logic             mid_empty;
  logic             mid_pop;
  res_t             back_res;
  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] out_dout;
  res_t             out_res;

  // Classify the incoming item against the configuration
  usrh_front #(
    .STRING_SLOTS(STRING_SLOTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .request_type  (request_type),
    .request_code  (request_code),
    .request_value (request_value),
    .request_index (request_index),
    .request_length(request_length),
    .cmd           (front_cmd)
  );

  // Decouple decode from execution
  usrh_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (front_cmd),
    .full (full),
    .pop  (mid_pop),
    .dout (mid_dout),
    .empty(mid_empty)
  );

  assign back_cmd = cmd_t'(mid_dout);

  // Apply state changes in order and form the result
  usrh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!mid_empty),
    .cmd      (back_cmd),
    .cmd_pop  (mid_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  // Hold finished results until the receiver takes them
  usrh_fifo #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (back_res),
    .full (res_full),
    .pop  (pop),
    .dout (out_dout),
    .empty(empty)
  );

  assign out_res         = res_t'(out_dout);
  assign status          = out_res.status;
  assign stall_ep0       = out_res.stall_ep0;
  assign unhalt_valid    = out_res.unhalt_valid;
  assign unhalt_endpoint = out_res.unhalt_endpoint;
  assign response_source = out_res.response_source;
  assign response_length = out_res.response_length;
  assign inline_data     = out_res.inline_data;
  assign string_slot     = out_res.string_slot;
  assign device_state    = out_res.device_state;
  assign device_address  = out_res.device_address;
  assign wakeup_enabled  = out_res.wakeup_enabled;
  assign ep0_phase       = out_res.ep0_phase;

  // A stall is only ever reported on an unsupported request
  a_stall_has_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && stall_ep0) |-> status)
    else $error("stall without not-supported status");

  // Clearing a halt is a handled request with no data stage
  a_unhalt_no_reply: assert property (@(posedge clk) disable iff (rst)
    (!empty && unhalt_valid) |-> (!status && response_source == SRC_NONE))
    else $error("unhalt with reply or failure");

  // No reply source means no reply bytes
  a_none_zero_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && response_source == SRC_NONE) |-> (response_length == '0))
    else $error("reply length without source");

  // An executed command always lands in the result queue
  a_exec_lands: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !empty)
    else $error("result lost after execution");

endmodule

[hdl/usrh_fifo.sv]
// Small register queue with first-word fall-through.
// Generic; no package dependency.
module usrh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/usrh_front.sv]
// Front end: configuration registers and classification of each event.
// Depends on usrh_pkg.
module usrh_front import usrh_pkg::*; #(
  parameter int STRING_SLOTS = STRING_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [2:0]  operation,
  input  logic [7:0]  request_type,
  input  logic [7:0]  request_code,
  input  logic [15:0] request_value,
  input  logic [15:0] request_index,
  input  logic [15:0] request_length,
  output cmd_t        cmd
);

  logic [7:0]  device_desc_length;
  logic [15:0] config_desc_length;
  logic        dev_self_power;
  logic [2:0]  string_count;
  logic [15:0] string_entry [STRING_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      device_desc_length <= DEVICE_LEN_RESET;
      config_desc_length <= '0;
      dev_self_power     <= 1'b0;
      string_count       <= '0;
      for (int j = 0; j < STRING_SLOTS; j++) begin
        string_entry[j] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEVICE_LEN: device_desc_length <= cfg_data[7:0];
        REG_CONFIG_LEN: config_desc_length <= cfg_data;
        REG_SELF_POWER: dev_self_power     <= cfg_data[0];
        REG_STRING_CNT: string_count       <= cfg_data[2:0];
        default: begin
          // string slots, only those the table holds
          for (int j = 0; j < STRING_SLOTS; j++) begin
            if (j == int'(cfg_index[1:0])) begin
              string_entry[j] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  // String lookup: first matching slot below the valid count
  logic       str_found;
  logic [1:0] str_slot;
  logic [7:0] str_chars;

  always_comb begin
    str_found = 1'b0;
    str_slot  = '0;
    str_chars = '0;
    for (int k = 0; k < STRING_SLOTS; k++) begin
      if (!str_found && (k < int'(string_count)) &&
          (string_entry[k][7:0] == request_value[7:0])) begin
        str_found = 1'b1;
        str_slot  = 2'(k);
        str_chars = string_entry[k][15:8];
      end
    end
  end

  always_comb begin
    cmd = '0;
    unique case (operation)
      OP_SETUP: begin
        if ((request_type & TYPE_MASK) != '0) begin
          cmd.status = 1'b1;
        end else begin
          unique case (request_code)
            REQ_GET_DESCRIPTOR: begin
              unique case (request_value[15:8])
                DESC_DEVICE: begin
                  cmd.response_source = SRC_DEVICE;
                  cmd.response_length = clip16({8'd0, device_desc_length}, request_length);
                end
                DESC_CONFIG: begin
                  cmd.response_source = SRC_CONFIG;
                  cmd.response_length = clip16(config_desc_length, request_length);
                end
                DESC_STRING: begin
                  if (request_value[7:0] == '0) begin
                    cmd.response_source = SRC_LANGID;
                    cmd.inline_data     = LANGID_REPLY;
                    cmd.response_length = clip16(16'd4, request_length);
                  end else if (str_found) begin
                    cmd.response_source = SRC_STRING;
                    cmd.string_slot     = str_slot;
                    cmd.response_length =
                      clip16({7'd0, str_chars, 1'b0} + 16'd2, request_length);
                  end
                end
                default: begin
                  cmd.status    = 1'b1;
                  cmd.stall_ep0 = 1'b1;
                end
              endcase
            end
            REQ_SET_ADDRESS: begin
              cmd.act = ACT_SET_ADDRESS;
              cmd.arg = request_value[7:0];
            end
            REQ_GET_CONFIG: begin
              cmd.act             = ACT_GET_CONFIG;
              cmd.response_source = SRC_INLINE;
              cmd.response_length = clip16(16'd1, request_length);
            end
            REQ_SET_CONFIG: begin
              cmd.act = ACT_SET_CONFIG;
              cmd.arg = request_value[7:0];
            end
            REQ_GET_STATUS: begin
              // wakeup bit is merged in by the back end
              cmd.act             = ACT_GET_STATUS;
              cmd.response_source = SRC_INLINE;
              cmd.inline_data     = {31'd0, dev_self_power};
              cmd.response_length = clip16(16'd2, request_length);
            end
            REQ_SET_FEATURE: begin
              if (request_value == FEAT_WAKEUP) begin
                cmd.act = ACT_SET_WAKEUP;
              end
            end
            REQ_CLEAR_FEATURE: begin
              if (request_value == FEAT_WAKEUP) begin
                cmd.act = ACT_CLR_WAKEUP;
              end else if (request_value == FEAT_EP_HALT &&
                           (request_type & RECIPIENT_MASK) == RECIPIENT_EP) begin
                cmd.unhalt_valid    = 1'b1;
                cmd.unhalt_endpoint = request_index[7:0];
              end
            end
            default: begin
              cmd.status    = 1'b1;
              cmd.stall_ep0 = 1'b1;
            end
          endcase
        end
      end
      OP_BUS_RST: cmd.act = ACT_BUS_RESET;
      OP_SUSPEND: cmd.act = ACT_SUSPEND;
      OP_RESUME:  cmd.act = ACT_RESUME;
      OP_IN_DONE: cmd.act = ACT_IN_DONE;
      default:    cmd.act = ACT_NONE;
    endcase
  end

endmodule

[hdl/usrh_back.sv]
// Back end: device state registers and completion of each classified item.
// Depends on usrh_pkg.
module usrh_back import usrh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  logic [2:0] dev_state;
  logic [7:0] config_value;
  logic [6:0] address;
  logic       wakeup;
  logic       ep0_phase;

  logic [2:0] dev_state_next;
  logic [7:0] config_value_next;
  logic [6:0] address_next;
  logic       wakeup_next;
  logic       ep0_phase_next;
  logic       fire;

  assign fire     = cmd_valid && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;

  always_comb begin
    dev_state_next    = dev_state;
    config_value_next = config_value;
    address_next      = address;
    wakeup_next       = wakeup;
    ep0_phase_next    = ep0_phase;
    unique case (cmd.act)
      ACT_SET_ADDRESS: begin
        address_next   = cmd.arg[6:0];
        dev_state_next = ST_ADDRESS;
      end
      ACT_SET_CONFIG: begin
        config_value_next = cmd.arg;
        dev_state_next    = (cmd.arg != '0) ? ST_CONFIGURED : ST_ADDRESS;
      end
      ACT_SET_WAKEUP: wakeup_next = 1'b1;
      ACT_CLR_WAKEUP: wakeup_next = 1'b0;
      ACT_BUS_RESET: begin
        dev_state_next    = ST_DEFAULT;
        config_value_next = '0;
        address_next      = '0;
        ep0_phase_next    = 1'b0;
      end
      ACT_SUSPEND: dev_state_next = ST_SUSPENDED;
      ACT_RESUME:  dev_state_next = (config_value != '0) ? ST_CONFIGURED : ST_ADDRESS;
      ACT_IN_DONE: ep0_phase_next = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res.status          = cmd.status;
    res.stall_ep0       = cmd.stall_ep0;
    res.unhalt_valid    = cmd.unhalt_valid;
    res.unhalt_endpoint = cmd.unhalt_endpoint;
    res.response_source = cmd.response_source;
    res.response_length = cmd.response_length;
    res.string_slot     = cmd.string_slot;
    res.inline_data     = cmd.inline_data;
    if (cmd.act == ACT_GET_CONFIG) begin
      res.inline_data = {24'd0, config_value};
    end else if (cmd.act == ACT_GET_STATUS) begin
      res.inline_data = cmd.inline_data | {30'd0, wakeup, 1'b0};
    end
    res.device_state   = dev_state_next;
    res.device_address = address_next;
    res.wakeup_enabled = wakeup_next;
    res.ep0_phase      = ep0_phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_state    <= ST_POWERED;
      config_value <= '0;
      address      <= '0;
      wakeup       <= 1'b0;
      ep0_phase    <= 1'b0;
    end else if (fire) begin
      dev_state    <= dev_state_next;
      config_value <= config_value_next;
      address      <= address_next;
      wakeup       <= wakeup_next;
      ep0_phase    <= ep0_phase_next;
    end
  end

endmodule

[dv/usb_standard_request_handler_core_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for usb_standard_request_handler_core: endpoint zero events
// go in through the push/full queue, replies come out through empty/pop.
// Depends on usrh_pkg and the RTL; every reply is checked against an in-bench model or a typed script row.
module usb_standard_request_handler_core_test;
  import usrh_pkg::*;

  localparam int CLK_HALF = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_REGS = 8;
  localparam logic [2:0] REG_STRING_0 = 3'd4;
  localparam logic [2:0] OP_LAST_CODE = 3'd7;
  localparam logic [7:0] STD_REQUESTS [7] = '{REQ_GET_STATUS, REQ_CLEAR_FEATURE,
    REQ_SET_FEATURE, REQ_SET_ADDRESS, REQ_GET_DESCRIPTOR, REQ_GET_CONFIG, REQ_SET_CONFIG};

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
  } ep0_event_t;

  typedef struct {
    ep0_event_t ev;
    bit         typed;
    res_t       want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        push;
  logic        full;
  logic [2:0]  operation;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_index;
  logic [15:0] request_length;
  logic        empty;
  logic        pop;
  logic        status;
  logic        stall_ep0;
  logic        unhalt_valid;
  logic [7:0]  unhalt_endpoint;
  logic [2:0]  response_source;
  logic [15:0] response_length;
  logic [31:0] inline_data;
  logic [1:0]  string_slot;
  logic [2:0]  device_state;
  logic [6:0]  device_address;
  logic        wakeup_enabled;
  logic        ep0_phase;

  // Model of the handler: configuration copy and device state
  logic [7:0]  dev_desc_len;
  logic [15:0] conf_desc_len;
  logic        self_pwr;
  logic [2:0]  str_count;
  logic [15:0] str_table [STRING_SLOTS_DEFAULT];
  logic [2:0]  dev_state;
  logic [7:0]  cfg_value;
  logic [6:0]  dev_addr;
  logic        wakeup;
  logic        in_status_stage;

  res_t        replies_due [$];
  script_row_t script [$];
  int          mismatch_count = 0;
  int unsigned cycles_run = 0;
  int          feed_idle_pct = 0;
  int          drain_idle_pct = 0;
  int          drain_hold_request = 0;

  usb_standard_request_handler_core u_dut (.*);

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) cycles_run <= cycles_run + 1;

  function automatic logic [15:0] clipped(input logic [15:0] n, input logic [15:0] cap);
    if (n < cap) return n;
    return cap;
  endfunction

  function automatic ep0_event_t make_event(input logic [2:0] op, input logic [7:0] rtype,
      input logic [7:0] code, input logic [15:0] value, input logic [15:0] index,
      input logic [15:0] length);
    return '{op: op, rtype: rtype, code: code, value: value, index: index, length: length};
  endfunction

  // Decode one event, advance the device state and return the reply it owes.
  function automatic res_t handle_event(input ep0_event_t ev);
    res_t        r;
    logic [7:0]  dtype;
    logic [7:0]  didx;
    logic [15:0] chars;
    int          n;
    bit          hit;
    r = '0;
    hit = 1'b0;
    dtype = ev.value[15:8];
    didx = ev.value[7:0];
    case (ev.op)
      OP_SETUP: begin
        if ((ev.rtype & TYPE_MASK) != 8'h00) begin
          // class and vendor requests are refused without a stall
          r.status = 1'b1;
        end else begin
          case (ev.code)
            REQ_GET_DESCRIPTOR: begin
              case (dtype)
                DESC_DEVICE: begin
                  r.response_source = SRC_DEVICE;
                  r.response_length = clipped({8'h00, dev_desc_len}, ev.length);
                end
                DESC_CONFIG: begin
                  r.response_source = SRC_CONFIG;
                  r.response_length = clipped(conf_desc_len, ev.length);
                end
                DESC_STRING: begin
                  if (didx == 8'h00) begin
                    r.response_source = SRC_LANGID;
                    r.inline_data = LANGID_REPLY;
                    r.response_length = clipped(16'd4, ev.length);
                  end else begin
                    // a count above the table size searches the whole table
                    n = (str_count > STRING_SLOTS_DEFAULT) ? STRING_SLOTS_DEFAULT
                                                           : int'(str_count);
                    for (int k = 0; k < n; k++) begin
                      if (!hit && str_table[k][7:0] == didx) begin
                        hit = 1'b1;
                        chars = {8'h00, str_table[k][15:8]};
                        r.response_source = SRC_STRING;
                        r.string_slot = 2'(k);
                        r.response_length = clipped(16'd2 + (chars << 1), ev.length);
                      end
                    end
                  end
                end
                default: begin
                  r.status = 1'b1;
                  r.stall_ep0 = 1'b1;
                end
              endcase
            end
            REQ_SET_ADDRESS: begin
              dev_addr = ev.value[6:0];
              dev_state = ST_ADDRESS;
            end
            REQ_GET_CONFIG: begin
              r.response_source = SRC_INLINE;
              r.inline_data = {24'h0, cfg_value};
              r.response_length = clipped(16'd1, ev.length);
            end
            REQ_SET_CONFIG: begin
              cfg_value = ev.value[7:0];
              dev_state = (cfg_value != 8'h00) ? ST_CONFIGURED : ST_ADDRESS;
            end
            REQ_GET_STATUS: begin
              // device status whatever the recipient
              r.response_source = SRC_INLINE;
              r.inline_data = {30'h0, wakeup, self_pwr};
              r.response_length = clipped(16'd2, ev.length);
            end
            REQ_SET_FEATURE: begin
              if (ev.value == FEAT_WAKEUP) wakeup = 1'b1;
            end
            REQ_CLEAR_FEATURE: begin
              if (ev.value == FEAT_WAKEUP) begin
                wakeup = 1'b0;
              end else if (ev.value == FEAT_EP_HALT &&
                           (ev.rtype & RECIPIENT_MASK) == RECIPIENT_EP) begin
                r.unhalt_valid = 1'b1;
                r.unhalt_endpoint = ev.index[7:0];
              end
            end
            default: begin
              r.status = 1'b1;
              r.stall_ep0 = 1'b1;
            end
          endcase
        end
      end
      OP_BUS_RST: begin
        // the wakeup flag survives a bus reset
        dev_state = ST_DEFAULT;
        cfg_value = 8'h00;
        dev_addr = 7'h00;
        in_status_stage = 1'b0;
      end
      OP_SUSPEND: dev_state = ST_SUSPENDED;
      OP_RESUME: dev_state = (cfg_value != 8'h00) ? ST_CONFIGURED : ST_ADDRESS;
      OP_IN_DONE: in_status_stage = 1'b1;
      default: ;
    endcase
    r.device_state = dev_state;
    r.device_address = dev_addr;
    r.wakeup_enabled = wakeup;
    r.ep0_phase = in_status_stage;
    return r;
  endfunction

  // Mostly well-formed standard requests with random content, some bus events,
  // some noise with class or vendor types and undefined codes.
  function automatic ep0_event_t random_event();
    ep0_event_t ev;
    int         pick;
    ev.op = OP_SETUP;
    ev.rtype = 8'($urandom);
    ev.code = 8'($urandom);
    ev.value = 16'($urandom);
    ev.index = 16'($urandom);
    ev.length = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(600));
    pick = $urandom_range(99);
    if (pick < 20) begin
      if ($urandom_range(19) == 0)
        ev.op = 3'($urandom_range(int'(OP_IN_DONE) + 1, int'(OP_LAST_CODE)));
      else
        ev.op = 3'($urandom_range(int'(OP_BUS_RST), int'(OP_IN_DONE)));
    end else if (pick >= 28) begin
      ev.rtype = ev.rtype & ~TYPE_MASK;
      if ($urandom_range(9) != 0) ev.code = STD_REQUESTS[$urandom_range(6)];
      case (ev.code)
        REQ_GET_DESCRIPTOR: begin
          case ($urandom_range(5))
            0: ev.value[15:8] = DESC_DEVICE;
            1: ev.value[15:8] = DESC_CONFIG;
            2, 3, 4: ev.value[15:8] = DESC_STRING;
            default: ;
          endcase
          pick = $urandom_range(9);
          if (pick < 7) ev.value[7:0] = str_table[$urandom_range(STRING_SLOTS_DEFAULT - 1)][7:0];
          else if (pick == 7) ev.value[7:0] = 8'h00;
        end
        REQ_SET_FEATURE, REQ_CLEAR_FEATURE: begin
          if ($urandom_range(3) != 0) ev.value = 16'($urandom_range(1));
          if ($urandom_range(1) == 0) ev.rtype = (ev.rtype & ~RECIPIENT_MASK) | RECIPIENT_EP;
        end
        REQ_SET_CONFIG: begin
          if ($urandom_range(2) == 0) ev.value[7:0] = 8'h00;
        end
        default: ;
      endcase
    end
    return ev;
  endfunction

  function automatic void add_row(input ep0_event_t ev, input bit typed, input res_t want);
    script.push_back('{ev: ev, typed: typed, want: want});
  endfunction

  // Offer one item, idling at random first; leave push high once it is taken.
  task automatic send_event(input ep0_event_t ev, input bit typed, input res_t want);
    res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < feed_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    operation <= ev.op;
    request_type <= ev.rtype;
    request_code <= ev.code;
    request_value <= ev.value;
    request_index <= ev.index;
    request_length <= ev.length;
    do @(posedge clk); while (full);
    predicted = handle_event(ev);
    replies_due.push_back(typed ? want : predicted);
  endtask

  // Drop push and hold until every owed reply is in, then let the pipe settle.
  task automatic drain_replies();
    @(negedge clk);
    push <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers in index order; only called with the block idle.
  task automatic apply_settings(input logic [NUM_REGS-1:0][15:0] vals);
    for (int r = 0; r < NUM_REGS; r++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= 3'(r);
      cfg_data <= vals[r];
      @(posedge clk);
      case (3'(r))
        REG_DEVICE_LEN: dev_desc_len = vals[r][7:0];
        REG_CONFIG_LEN: conf_desc_len = vals[r];
        REG_SELF_POWER: self_pwr = vals[r][0];
        REG_STRING_CNT: str_count = vals[r][2:0];
        default: str_table[r - int'(REG_STRING_0)] = vals[r];
      endcase
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic note_mismatch(input string what, input logic [RES_W-1:0] want,
      input logic [RES_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
  endtask

  // Reply checker: values are sampled at the edge, before the block updates them.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && pop && !empty) begin
      got = {status, stall_ep0, unhalt_valid, unhalt_endpoint, response_source,
             response_length, inline_data, string_slot, device_state, device_address,
             wakeup_enabled, ep0_phase};
      if (replies_due.size() == 0) begin
        note_mismatch("unsolicited reply", '0, got);
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status)
          note_mismatch("status", RES_W'(want.status), RES_W'(got.status));
        if (got.stall_ep0 !== want.stall_ep0)
          note_mismatch("stall_ep0", RES_W'(want.stall_ep0), RES_W'(got.stall_ep0));
        if (got.unhalt_valid !== want.unhalt_valid)
          note_mismatch("unhalt_valid", RES_W'(want.unhalt_valid),
                        RES_W'(got.unhalt_valid));
        if (got.unhalt_endpoint !== want.unhalt_endpoint)
          note_mismatch("unhalt_endpoint", RES_W'(want.unhalt_endpoint),
                        RES_W'(got.unhalt_endpoint));
        if (got.response_source !== want.response_source)
          note_mismatch("response_source", RES_W'(want.response_source),
                        RES_W'(got.response_source));
        if (got.response_length !== want.response_length)
          note_mismatch("response_length", RES_W'(want.response_length),
                        RES_W'(got.response_length));
        if (got.inline_data !== want.inline_data)
          note_mismatch("inline_data", RES_W'(want.inline_data), RES_W'(got.inline_data));
        if (got.string_slot !== want.string_slot)
          note_mismatch("string_slot", RES_W'(want.string_slot), RES_W'(got.string_slot));
        if (got.device_state !== want.device_state)
          note_mismatch("device_state", RES_W'(want.device_state),
                        RES_W'(got.device_state));
        if (got.device_address !== want.device_address)
          note_mismatch("device_address", RES_W'(want.device_address),
                        RES_W'(got.device_address));
        if (got.wakeup_enabled !== want.wakeup_enabled)
          note_mismatch("wakeup_enabled", RES_W'(want.wakeup_enabled),
                        RES_W'(got.wakeup_enabled));
        if (got.ep0_phase !== want.ep0_phase)
          note_mismatch("ep0_phase", RES_W'(want.ep0_phase), RES_W'(got.ep0_phase));
      end
    end
  end

  // Reply side: random pops, or a long counted hold-off when one is requested.
  initial begin
    int hold_left;
    pop = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (drain_hold_request != 0) begin
        hold_left = drain_hold_request;
        drain_hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= drain_idle_pct);
      end
    end
  end

  initial begin
    wait (cycles_run >= CYCLE_LIMIT);
    $display("usb_standard_request_handler_core regression: fail");
    $finish;
  end

  initial begin
    logic [NUM_REGS-1:0][15:0] settings;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    push = 1'b0;
    operation = OP_SETUP;
    request_type = '0;
    request_code = '0;
    request_value = '0;
    request_index = '0;
    request_length = '0;

    // model state as it leaves reset
    dev_desc_len = DEVICE_LEN_RESET;
    conf_desc_len = '0;
    self_pwr = 1'b0;
    str_count = '0;
    foreach (str_table[k]) str_table[k] = '0;
    dev_state = ST_POWERED;
    cfg_value = '0;
    dev_addr = '0;
    wakeup = 1'b0;
    in_status_stage = 1'b0;

    // Directed script. Typed rows hold replies that follow straight from the
    // reset state; the rest are left to the model.
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'hFFFF), 1'b1,
            '{response_source: SRC_INLINE, response_length: 16'd2, default: '0});
    add_row(make_event(OP_SETUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1,
            '{status: 1'b1, default: '0});
    add_row(make_event(OP_SETUP, 8'h00, 8'hFF, 16'h0000, 16'h0000, 16'h0000), 1'b1,
            '{status: 1'b1, stall_ep0: 1'b1, default: '0});
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'hFF00, 16'h0000, 16'h0040),
            1'b1, '{status: 1'b1, stall_ep0: 1'b1, default: '0});
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'h0100, 16'h0000, 16'hFFFF),
            1'b1, '{response_source: SRC_DEVICE, response_length: 16'd18, default: '0});
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'h0100, 16'h0000, 16'h0000),
            1'b1, '{response_source: SRC_DEVICE, default: '0});
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'h0200, 16'h0000, 16'hFFFF),
            1'b1, '{response_source: SRC_CONFIG, default: '0});
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'h0300, 16'h0000, 16'hFFFF),
            1'b1, '{response_source: SRC_LANGID, response_length: 16'd4,
                    inline_data: LANGID_REPLY, default: '0});
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'h0300, 16'h0409, 16'h0003),
            1'b1, '{response_source: SRC_LANGID, response_length: 16'd3,
                    inline_data: LANGID_REPLY, default: '0});
    // string index absent from the table: handled, nothing to send
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'h03FF, 16'h0409, 16'hFFFF),
            1'b1, '0);
    // string lookups with a count above the table size
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'h0342, 16'h0409, 16'hFFFF),
            1'b0, '0);
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'h0303, 16'h0409, 16'hFFFF),
            1'b0, '0);
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_DESCRIPTOR, 16'h0301, 16'h0409, 16'h0005),
            1'b0, '0);
    add_row(make_event(OP_BUS_RST, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b1,
            '{device_state: ST_DEFAULT, default: '0});
    add_row(make_event(OP_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b1,
            '{device_state: ST_DEFAULT, ep0_phase: 1'b1, default: '0});
    add_row(make_event(OP_SETUP, 8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000, 16'h0000),
            1'b0, '0);
    add_row(make_event(OP_SETUP, 8'h00, REQ_SET_CONFIG, 16'h00FF, 16'h0000, 16'h0000),
            1'b0, '0);
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'h0000),
            1'b0, '0);
    add_row(make_event(OP_SETUP, 8'h80, REQ_GET_CONFIG, 16'h0000, 16'h0000, 16'hFFFF),
            1'b0, '0);
    add_row(make_event(OP_SETUP, 8'h00, REQ_SET_FEATURE, FEAT_WAKEUP, 16'h0000, 16'h0000),
            1'b0, '0);
    add_row(make_event(OP_SETUP, 8'h81, REQ_GET_STATUS, 16'h0000, 16'h0001, 16'h0001),
            1'b0, '0);
    add_row(make_event(OP_SETUP, 8'h02, REQ_CLEAR_FEATURE, FEAT_EP_HALT, 16'hFFFF,
            16'h0000), 1'b0, '0);
    add_row(make_event(OP_SETUP, 8'h01, REQ_CLEAR_FEATURE, FEAT_EP_HALT, 16'h0081,
            16'h0000), 1'b0, '0);
    add_row(make_event(OP_SUSPEND, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b0, '0);
    add_row(make_event(OP_RESUME, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b0, '0);
    add_row(make_event(OP_BUS_RST, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b0, '0);
    add_row(make_event(OP_SETUP, 8'h00, REQ_CLEAR_FEATURE, FEAT_WAKEUP, 16'h0000, 16'h0000),
            1'b0, '0);
    add_row(make_event(OP_LAST_CODE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0);
    add_row(make_event(OP_RESUME, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000), 1'b0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Keep the descriptor lengths and power flag at their reset values, load
    // a string table and a count beyond the number of slots.
    settings = '0;
    settings[REG_DEVICE_LEN] = {8'h00, DEVICE_LEN_RESET};
    settings[REG_STRING_CNT] = 16'd7;
    settings[REG_STRING_0] = 16'h0A01;
    settings[REG_STRING_0 + 3'd1] = 16'h0002;
    settings[REG_STRING_0 + 3'd2] = 16'hFF03;
    settings[REG_STRING_0 + 3'd3] = 16'h0542;
    apply_settings(settings);

    feed_idle_pct = 37;
    drain_idle_pct = 75;
    foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);
    drain_replies();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // receiver sparse then sender sparse, then flat out
      if (phase < 2) begin
        feed_idle_pct = 37;
        drain_idle_pct = 75;
      end else if (phase < 4) begin
        feed_idle_pct = 75;
        drain_idle_pct = 37;
      end else begin
        feed_idle_pct = 0;
        drain_idle_pct = 0;
      end

      for (int r = 0; r < NUM_REGS; r++) settings[r] = 16'($urandom);
      settings[REG_STRING_CNT] = 16'($urandom_range(7));
      case (phase)
        0: begin
          // upper extremes
          settings[REG_DEVICE_LEN] = 16'hFFFF;
          settings[REG_CONFIG_LEN] = 16'hFFFF;
          settings[REG_SELF_POWER] = 16'hFFFF;
          settings[REG_STRING_CNT] = 16'(STRING_SLOTS_DEFAULT);
          settings[REG_STRING_0 + 3'd3] = 16'hFFFF;
        end
        1: settings = '0;
        2: settings[REG_STRING_CNT] = 16'hFFFF;
        default: ;
      endcase
      apply_settings(settings);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_event(random_event(), 1'b0, '0);
        // starve the reply side until the block backs up into full
        if (phase == 0 && i == 40) drain_hold_request = HOLD_OFF_CYCLES;
        // pause the sender until everything owed has come back
        if (phase == 4 && i == ITEMS_PER_PHASE / 2) drain_replies();
      end
      drain_replies();
    end

    if (mismatch_count == 0) begin
      $display("usb_standard_request_handler_core regression: pass");
    end else begin
      $display("usb_standard_request_handler_core regression: fail");
    end
    $finish;
  end

endmodule
